// File: sv/pras_pkg.sv
// Shared types and constants for the periodic report ack scheduler.
`timescale 1ns / 1ps
`default_nettype none

package pras_pkg;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [15:0] DEFAULT_PERIOD_S = 16'd60;
    localparam logic [31:0] TIMEOUT_RESET_MS = 32'd1000;
    localparam logic [7:0]  STATUS_SUCCESS   = 8'hFF;

    typedef enum logic [1:0] {
        ACT_SEC_TICK = 2'd0,
        ACT_MS_TICK  = 2'd1,
        ACT_PROCESS  = 2'd2,
        ACT_ACK      = 2'd3
    } action_t;

    typedef enum logic {
        REG_UPLOAD_PERIOD = 1'b0,
        REG_ACK_TIMEOUT   = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] tick_ms;
        logic        ack_has_status;
        logic [7:0]  ack_status;
    } req_t;

    typedef struct packed {
        logic        send_report;
        logic [31:0] report_timestamp;
        logic        waiting_ack;
        logic        timeout_event;
        logic        ack_error_event;
        logic [31:0] errors_total;
    } rsp_t;

    typedef struct packed {
        logic [15:0] upload_period_s;
        logic [31:0] ack_limit_ms;
    } cfg_t;

endpackage

`default_nettype wire

// File: sv/periodic_report_ack_scheduler.sv
// Usage: events (second tick, millisecond tick, process, ack) enter on the
// req channel as valid/ready beats, one per cycle while rsp_ready is high.
// Each event yields exactly one result beat on the rsp channel, in order:
// whether a report is sent now, the seconds timestamp, the ack wait flag,
// the timeout and failed-ack flags and the running error count.
// An accepted event is held in the input register; the scheduler state and
// the result register are updated together when it advances, which it does
// when the result register is empty or its beat is being taken.
// Throughput is one event per cycle while rsp_ready is high; the state
// update between the input and result registers is combinational.
// When rsp_ready is low the result register holds; the input register fills
// behind it and req_ready drops only when both are full.
// Reset clears all scheduler state, empties both registers, sets the period
// register to zero (meaning sixty seconds) and the ack timeout to 1000 ms.
// The APB port holds the period at address 0 and the timeout at address 4;
// write it only while no event is in flight.
`timescale 1ns / 1ps
`default_nettype none

module periodic_report_ack_scheduler (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    output logic                                     req_ready,
    input  pras_pkg::req_t                           req,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_ready,
    output pras_pkg::rsp_t                           rsp,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [pras_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [pras_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [pras_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    pras_pkg::cfg_t  cfg;
    pras_pkg::req_t  s1_item_reg;
    logic            s1_valid_reg;
    pras_pkg::rsp_t  rsp_reg;
    logic            rsp_valid_reg;
    pras_pkg::rsp_t  core_result;
    logic            s1_advance;
    logic            req_beat;

    pras_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pras_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (s1_advance),
        .item    (s1_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    assign s1_advance = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready  = !s1_valid_reg || !rsp_valid_reg || rsp_ready;
    assign req_beat   = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_beat)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_beat)
        begin
            s1_item_reg <= req;
        end
        if (s1_advance)
        begin
            rsp_reg <= core_result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A report that was just sent always leaves the block waiting for its ack.
    a_send_waits: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.send_report |-> rsp.waiting_ack)
        else $error("send_report without waiting_ack");

    // A timeout or a failed ack always ends the wait.
    a_error_ends_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.timeout_event || rsp.ack_error_event) |-> !rsp.waiting_ack)
        else $error("error event while still waiting");

    // An empty result register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid_reg |-> req_ready)
        else $error("input stalled with empty result register");

    // Every event that leaves the input register lands in the result register.
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> rsp_valid_reg)
        else $error("result beat lost");

endmodule

`default_nettype wire

// File: sv/pras_regs.sv
// APB configuration registers: report period and ack timeout.
`timescale 1ns / 1ps
`default_nettype none

module pras_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [pras_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [pras_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [pras_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output pras_pkg::cfg_t                           cfg
);

    logic [15:0]            period_reg;
    logic [31:0]            timeout_reg;
    logic                   wr_en;
    pras_pkg::reg_index_t   reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = pras_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= '0;
            timeout_reg <= pras_pkg::TIMEOUT_RESET_MS;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                pras_pkg::REG_UPLOAD_PERIOD: period_reg  <= pwdata[15:0];
                pras_pkg::REG_ACK_TIMEOUT:   timeout_reg <= pwdata[31:0];
                default:                     period_reg  <= period_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            pras_pkg::REG_UPLOAD_PERIOD: prdata = {16'd0, period_reg};
            pras_pkg::REG_ACK_TIMEOUT:   prdata = timeout_reg;
            default:                     prdata = '0;
        endcase
    end

    assign cfg.upload_period_s = period_reg;
    assign cfg.ack_limit_ms    = timeout_reg;

endmodule

`default_nettype wire

// File: sv/pras_core.sv
// Scheduler state and the combinational update for one event.
`timescale 1ns / 1ps
`default_nettype none

module pras_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step_en,
    input  pras_pkg::req_t      item,
    input  pras_pkg::cfg_t      cfg,
    output pras_pkg::rsp_t      result
);

    logic [31:0] stamp_reg,     stamp_next;
    logic [15:0] period_cnt_reg, period_cnt_next;
    logic        pending_reg,   pending_next;
    logic        waiting_reg,   waiting_next;
    logic [31:0] wait_ms_reg,   wait_ms_next;
    logic [31:0] err_total_reg, err_total_next;

    logic [15:0] period;
    logic [16:0] cnt_inc;
    logic [31:0] wait_sum;
    logic        sent;
    logic        timed_out;
    logic        ack_err;

    assign period   = (cfg.upload_period_s == 16'd0) ? pras_pkg::DEFAULT_PERIOD_S
                                                     : cfg.upload_period_s;
    assign cnt_inc  = {1'b0, period_cnt_reg} + 17'd1;
    assign wait_sum = wait_ms_reg + {16'd0, item.tick_ms};

    always_comb
    begin
        stamp_next      = stamp_reg;
        period_cnt_next = period_cnt_reg;
        pending_next    = pending_reg;
        waiting_next    = waiting_reg;
        wait_ms_next    = wait_ms_reg;
        err_total_next  = err_total_reg;
        sent            = 1'b0;
        timed_out       = 1'b0;
        ack_err         = 1'b0;
        case (item.action)
            pras_pkg::ACT_SEC_TICK:
            begin
                stamp_next = stamp_reg + 32'd1;
                if (cnt_inc >= {1'b0, period})
                begin
                    period_cnt_next = '0;
                    pending_next    = 1'b1;
                end
                else
                begin
                    period_cnt_next = cnt_inc[15:0];
                end
            end
            pras_pkg::ACT_MS_TICK:
            begin
                if (waiting_reg)
                begin
                    wait_ms_next = wait_sum;
                    // The sum wraps at 32 bits before it is compared.
                    if (wait_sum >= cfg.ack_limit_ms)
                    begin
                        waiting_next   = 1'b0;
                        wait_ms_next   = '0;
                        err_total_next = err_total_reg + 32'd1;
                        timed_out      = 1'b1;
                    end
                end
            end
            pras_pkg::ACT_PROCESS:
            begin
                if (!waiting_reg && pending_reg)
                begin
                    waiting_next = 1'b1;
                    wait_ms_next = '0;
                    pending_next = 1'b0;
                    sent         = 1'b1;
                end
            end
            pras_pkg::ACT_ACK:
            begin
                if (item.ack_has_status && waiting_reg)
                begin
                    waiting_next = 1'b0;
                    wait_ms_next = '0;
                    if (item.ack_status != pras_pkg::STATUS_SUCCESS)
                    begin
                        err_total_next = err_total_reg + 32'd1;
                        ack_err        = 1'b1;
                    end
                end
            end
            default:
            begin
                stamp_next = stamp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_reg      <= '0;
            period_cnt_reg <= '0;
            pending_reg    <= 1'b0;
            waiting_reg    <= 1'b0;
            wait_ms_reg    <= '0;
            err_total_reg  <= '0;
        end
        else if (step_en)
        begin
            stamp_reg      <= stamp_next;
            period_cnt_reg <= period_cnt_next;
            pending_reg    <= pending_next;
            waiting_reg    <= waiting_next;
            wait_ms_reg    <= wait_ms_next;
            err_total_reg  <= err_total_next;
        end
    end

    assign result.send_report      = sent;
    assign result.report_timestamp = stamp_next;
    assign result.waiting_ack      = waiting_next;
    assign result.timeout_event    = timed_out;
    assign result.ack_error_event  = ack_err;
    assign result.errors_total     = err_total_next;

endmodule

`default_nettype wire

// File: verif/periodic_report_ack_scheduler_test.sv
// Self-checking testbench for the periodic report ack scheduler.
`timescale 1ns / 1ps

module periodic_report_ack_scheduler_test;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned HOLD_CYCLES = 64;
    localparam int unsigned WAIT_TICKS  = 16;

    typedef enum logic {
        ROW_EVENT = 1'b0,
        ROW_WRITE = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        pras_pkg::req_t        ev;
        logic                  typed;
        pras_pkg::rsp_t        want;
        pras_pkg::reg_index_t  idx;
        logic [31:0]           value;
    } plan_row_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_ready;
    pras_pkg::req_t                  req       = '0;
    logic                            rsp_valid;
    logic                            rsp_ready = 1'b0;
    pras_pkg::rsp_t                  rsp;
    logic                            psel      = 1'b0;
    logic                            penable   = 1'b0;
    logic                            pwrite    = 1'b0;
    logic [pras_pkg::APB_ADDR_W-1:0] paddr     = '0;
    logic [pras_pkg::APB_DATA_W-1:0] pwdata    = '0;
    logic [pras_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // Scheduler state as the block should hold it, plus the register shadows.
    logic [15:0] period_cfg    = 16'd0;
    logic [31:0] timeout_cfg   = pras_pkg::TIMEOUT_RESET_MS;
    logic [31:0] stamp_s       = 32'd0;
    logic [15:0] period_count  = 16'd0;
    logic        report_due    = 1'b0;
    logic        awaiting_ack  = 1'b0;
    logic [31:0] ack_wait_ms   = 32'd0;
    logic [31:0] err_tally     = 32'd0;

    pras_pkg::rsp_t expected_reports[$];
    plan_row_t      plan[$];
    int unsigned    mismatches  = 0;
    int unsigned    cycle_count = 0;
    bit             no_gaps     = 1'b0;
    bit             hold_rsp    = 1'b0;

    periodic_report_ack_scheduler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic pras_pkg::rsp_t predict_report(input pras_pkg::req_t ev);
        pras_pkg::rsp_t r;
        logic [31:0]    span;
        logic [31:0]    next_count;
        r = '0;
        case (ev.action)
            pras_pkg::ACT_SEC_TICK:
            begin
                span = (period_cfg == 16'd0) ? {16'd0, pras_pkg::DEFAULT_PERIOD_S}
                                             : {16'd0, period_cfg};
                stamp_s = stamp_s + 32'd1;
                next_count = {16'd0, period_count} + 32'd1;
                if (next_count >= span)
                begin
                    period_count = 16'd0;
                    report_due = 1'b1;
                end
                else
                begin
                    period_count = next_count[15:0];
                end
            end
            pras_pkg::ACT_MS_TICK:
            begin
                if (awaiting_ack)
                begin
                    // The sum wraps at 32 bits before the compare.
                    ack_wait_ms = ack_wait_ms + {16'd0, ev.tick_ms};
                    if (ack_wait_ms >= timeout_cfg)
                    begin
                        awaiting_ack = 1'b0;
                        ack_wait_ms = 32'd0;
                        err_tally = err_tally + 32'd1;
                        r.timeout_event = 1'b1;
                    end
                end
            end
            pras_pkg::ACT_PROCESS:
            begin
                if (!awaiting_ack && report_due)
                begin
                    awaiting_ack = 1'b1;
                    ack_wait_ms = 32'd0;
                    report_due = 1'b0;
                    r.send_report = 1'b1;
                end
            end
            default:
            begin
                if (ev.ack_has_status && awaiting_ack)
                begin
                    awaiting_ack = 1'b0;
                    ack_wait_ms = 32'd0;
                    if (ev.ack_status != pras_pkg::STATUS_SUCCESS)
                    begin
                        err_tally = err_tally + 32'd1;
                        r.ack_error_event = 1'b1;
                    end
                end
            end
        endcase
        r.report_timestamp = stamp_s;
        r.waiting_ack = awaiting_ack;
        r.errors_total = err_tally;
        return r;
    endfunction

    function automatic pras_pkg::req_t make_event(input pras_pkg::action_t a,
                                                  input logic [15:0] d,
                                                  input logic h, input logic [7:0] s);
        pras_pkg::req_t ev;
        ev.action = a;
        ev.tick_ms = d;
        ev.ack_has_status = h;
        ev.ack_status = s;
        return ev;
    endfunction

    function automatic pras_pkg::rsp_t report(input int unsigned snd, input int unsigned ts,
                                              input int unsigned w, input int unsigned tmo,
                                              input int unsigned aerr,
                                              input int unsigned errs);
        pras_pkg::rsp_t r;
        r.send_report = 1'(snd);
        r.report_timestamp = ts;
        r.waiting_ack = 1'(w);
        r.timeout_event = 1'(tmo);
        r.ack_error_event = 1'(aerr);
        r.errors_total = errs;
        return r;
    endfunction

    function automatic void plan_event(input pras_pkg::action_t a, input logic [15:0] d,
                                       input logic h, input logic [7:0] s);
        plan_row_t row;
        row = '0;
        row.kind = ROW_EVENT;
        row.ev = make_event(a, d, h, s);
        plan.push_back(row);
    endfunction

    function automatic void plan_checked(input pras_pkg::action_t a, input logic [15:0] d,
                                         input logic h, input logic [7:0] s,
                                         input pras_pkg::rsp_t want);
        plan_row_t row;
        row = '0;
        row.kind = ROW_EVENT;
        row.ev = make_event(a, d, h, s);
        row.typed = 1'b1;
        row.want = want;
        plan.push_back(row);
    endfunction

    function automatic void plan_write(input pras_pkg::reg_index_t idx,
                                       input logic [31:0] value);
        plan_row_t row;
        row = '0;
        row.kind = ROW_WRITE;
        row.idx = idx;
        row.value = value;
        plan.push_back(row);
    endfunction

    // Well-formed traffic mostly: second ticks at sec_pct percent to make sends
    // pending, the rest process, millisecond ticks and acks with a spread of statuses.
    function automatic pras_pkg::req_t random_event(input int sec_pct);
        pras_pkg::action_t a;
        logic [15:0]       d;
        logic [7:0]        s;
        logic              h;
        int                pick;
        if ($urandom_range(0, 99) < sec_pct)
        begin
            a = pras_pkg::ACT_SEC_TICK;
        end
        else
        begin
            pick = $urandom_range(0, 9);
            a = (pick < 3) ? pras_pkg::ACT_PROCESS
              : (pick < 7) ? pras_pkg::ACT_MS_TICK : pras_pkg::ACT_ACK;
        end
        if ($urandom_range(0, 3) == 0)
            d = 16'($urandom_range(0, 65535));
        else
            d = 16'($urandom_range(0, 300));
        if ($urandom_range(0, 2) == 0)
            s = pras_pkg::STATUS_SUCCESS;
        else
            s = 8'($urandom_range(0, 255));
        h = ($urandom_range(0, 4) != 0);
        return make_event(a, d, h, s);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    task automatic check_report(input pras_pkg::rsp_t got);
        pras_pkg::rsp_t want;
        if (expected_reports.size() == 0)
        begin
            mismatches++;
            $display("%0t: report beat expected none, got %h", $time, got);
        end
        else
        begin
            want = expected_reports.pop_front();
            check_field("send_report", {31'd0, want.send_report},
                        {31'd0, got.send_report});
            check_field("report_timestamp", want.report_timestamp, got.report_timestamp);
            check_field("waiting_ack", {31'd0, want.waiting_ack},
                        {31'd0, got.waiting_ack});
            check_field("timeout_event", {31'd0, want.timeout_event},
                        {31'd0, got.timeout_event});
            check_field("ack_error_event", {31'd0, want.ack_error_event},
                        {31'd0, got.ack_error_event});
            check_field("errors_total", want.errors_total, got.errors_total);
        end
    endtask

    // All driving tasks start and end at a falling edge.
    task automatic send_event(input pras_pkg::req_t ev, input logic typed,
                              input pras_pkg::rsp_t want);
        int             gap;
        pras_pkg::rsp_t predicted;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req <= ev;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = predict_report(ev);
        expected_reports.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_access(input pras_pkg::reg_index_t idx, input logic wr,
                              input logic [31:0] data, output logic [31:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic read_register_check(input pras_pkg::reg_index_t idx,
                                       input logic [31:0] want);
        logic [31:0] rd;
        apb_access(idx, 1'b0, 32'd0, rd);
        check_field(idx == pras_pkg::REG_UPLOAD_PERIOD ? "upload_period_s" : "ack_limit_ms",
                    want, rd);
    endtask

    task automatic write_register(input pras_pkg::reg_index_t idx, input logic [31:0] value);
        logic [31:0] rd;
        wait_drained();
        apb_access(idx, 1'b1, value, rd);
        if (idx == pras_pkg::REG_UPLOAD_PERIOD)
            period_cfg = value[15:0];
        else
            timeout_cfg = value;
        read_register_check(idx, idx == pras_pkg::REG_UPLOAD_PERIOD ? {16'd0, value[15:0]}
                                                                     : value);
    endtask

    // Result side: random hold-off before each beat, and one long hold on request.
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 15);
            if (hold_rsp)
            begin
                gap = HOLD_CYCLES;
                hold_rsp = 1'b0;
            end
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            check_report(rsp);
            @(negedge clk);
        end
    end

    initial
    begin
        int          phase;
        int          n;
        int          count;
        int          sec_pct;
        logic [31:0] period_v;
        logic [31:0] timeout_v;
        logic [15:0] d;

        // Directed table. Reset settings: period 0 (sixty seconds), timeout 1000 ms.
        plan_checked(pras_pkg::ACT_ACK, 16'h0000, 1'b1, 8'h00, report(0, 0, 0, 0, 0, 0));
        plan_checked(pras_pkg::ACT_MS_TICK, 16'hFFFF, 1'b1, 8'hFF, report(0, 0, 0, 0, 0, 0));
        plan_checked(pras_pkg::ACT_MS_TICK, 16'h0000, 1'b0, 8'h00, report(0, 0, 0, 0, 0, 0));
        plan_checked(pras_pkg::ACT_PROCESS, 16'hFFFF, 1'b1, 8'hFF, report(0, 0, 0, 0, 0, 0));
        plan_checked(pras_pkg::ACT_SEC_TICK, 16'hFFFF, 1'b1, 8'hFF, report(0, 1, 0, 0, 0, 0));
        plan_write(pras_pkg::REG_UPLOAD_PERIOD, 32'd1);
        plan_checked(pras_pkg::ACT_SEC_TICK, 16'h0000, 1'b0, 8'h00, report(0, 2, 0, 0, 0, 0));
        plan_checked(pras_pkg::ACT_PROCESS, 16'h0000, 1'b0, 8'h00, report(1, 2, 1, 0, 0, 0));
        plan_checked(pras_pkg::ACT_PROCESS, 16'h0000, 1'b0, 8'h00, report(0, 2, 1, 0, 0, 0));
        plan_checked(pras_pkg::ACT_ACK, 16'h0000, 1'b0, 8'h00, report(0, 2, 1, 0, 0, 0));
        plan_checked(pras_pkg::ACT_ACK, 16'h0000, 1'b1, 8'hFF, report(0, 2, 0, 0, 0, 0));
        plan_event(pras_pkg::ACT_SEC_TICK, 16'h1234, 1'b1, 8'h5A);
        plan_event(pras_pkg::ACT_PROCESS, 16'h0000, 1'b0, 8'h00);
        plan_checked(pras_pkg::ACT_ACK, 16'h0000, 1'b1, 8'h00, report(0, 3, 0, 0, 1, 1));
        plan_event(pras_pkg::ACT_SEC_TICK, 16'h0000, 1'b0, 8'h00);
        plan_event(pras_pkg::ACT_PROCESS, 16'h0000, 1'b0, 8'h00);
        plan_event(pras_pkg::ACT_MS_TICK, 16'd999, 1'b0, 8'h00);
        plan_checked(pras_pkg::ACT_MS_TICK, 16'd1, 1'b0, 8'h00, report(0, 4, 0, 1, 0, 2));
        plan_write(pras_pkg::REG_ACK_TIMEOUT, 32'd0);
        plan_event(pras_pkg::ACT_SEC_TICK, 16'h0000, 1'b0, 8'h00);
        plan_event(pras_pkg::ACT_PROCESS, 16'h0000, 1'b0, 8'h00);
        plan_checked(pras_pkg::ACT_MS_TICK, 16'h0000, 1'b0, 8'h00, report(0, 5, 0, 1, 0, 3));
        // Lowering the period below the running count makes a send pending on the next tick.
        plan_write(pras_pkg::REG_ACK_TIMEOUT, 32'hFFFF_FFFF);
        plan_write(pras_pkg::REG_UPLOAD_PERIOD, 32'hFFFF);
        plan_event(pras_pkg::ACT_SEC_TICK, 16'h0000, 1'b0, 8'h00);
        plan_event(pras_pkg::ACT_SEC_TICK, 16'h0000, 1'b0, 8'h00);
        plan_event(pras_pkg::ACT_SEC_TICK, 16'h0000, 1'b0, 8'h00);
        plan_write(pras_pkg::REG_UPLOAD_PERIOD, 32'd2);
        plan_event(pras_pkg::ACT_SEC_TICK, 16'h0000, 1'b0, 8'h00);
        plan_event(pras_pkg::ACT_PROCESS, 16'h0000, 1'b0, 8'h00);
        plan_event(pras_pkg::ACT_ACK, 16'hFFFF, 1'b1, 8'h80);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        read_register_check(pras_pkg::REG_UPLOAD_PERIOD, 32'd0);
        read_register_check(pras_pkg::REG_ACK_TIMEOUT, pras_pkg::TIMEOUT_RESET_MS);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
                write_register(plan[i].idx, plan[i].value);
            else
                send_event(plan[i].ev, plan[i].typed, plan[i].want);
        end

        for (phase = 0; phase < 10; phase++)
        begin
            count = 60;
            sec_pct = 30;
            case (phase)
                0: begin period_v = 32'd1; timeout_v = 32'd1000; end
                1: begin period_v = 32'd2; timeout_v = 32'd0; end
                2:
                begin
                    // Default period: ticks dominate so that sends still come up.
                    period_v = 32'd0;
                    timeout_v = 32'd1000;
                    count = 160;
                    sec_pct = 75;
                end
                3: begin period_v = 32'd3; timeout_v = 32'd1; end
                4: begin period_v = 32'hFFFF; timeout_v = 32'hFFFF_FFFF; end
                5: begin period_v = $urandom_range(1, 8); timeout_v = $urandom_range(0, 3000); end
                6: begin period_v = 32'd1; timeout_v = 32'd65535; end
                7: begin period_v = $urandom_range(1, 6); timeout_v = $urandom; end
                8: begin period_v = 32'd2; timeout_v = 32'd500; end
                default:
                begin
                    period_v = $urandom_range(0, 4);
                    timeout_v = $urandom_range(0, 2000);
                end
            endcase
            write_register(pras_pkg::REG_UPLOAD_PERIOD, period_v);
            write_register(pras_pkg::REG_ACK_TIMEOUT, timeout_v);
            for (n = 0; n < count; n++)
            begin
                if (n % 40 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                if (phase == 2 && n == 0)
                begin
                    // Results back up behind a long hold while events keep coming.
                    no_gaps = 1'b1;
                    hold_rsp = 1'b1;
                end
                if (phase == 4 && n == count / 2)
                    wait_drained();
                send_event(random_event(sec_pct), 1'b0, '0);
            end
        end

        // Long wait at the largest timeout: large ticks pile up without a timeout.
        write_register(pras_pkg::REG_UPLOAD_PERIOD, 32'd1);
        write_register(pras_pkg::REG_ACK_TIMEOUT, 32'hFFFF_FFFF);
        no_gaps = 1'b1;
        send_event(make_event(pras_pkg::ACT_ACK, 16'h0000, 1'b1, pras_pkg::STATUS_SUCCESS),
                   1'b0, '0);
        send_event(make_event(pras_pkg::ACT_SEC_TICK, 16'h0000, 1'b0, 8'h00), 1'b0, '0);
        send_event(make_event(pras_pkg::ACT_PROCESS, 16'h0000, 1'b0, 8'h00), 1'b0, '0);
        repeat (WAIT_TICKS)
        begin
            d = 16'($urandom_range(62000, 65535));
            send_event(make_event(pras_pkg::ACT_MS_TICK, d, 1'b0, 8'h00), 1'b0, '0);
        end
        send_event(make_event(pras_pkg::ACT_ACK, 16'h0000, 1'b1, pras_pkg::STATUS_SUCCESS),
                   1'b0, '0);

        wait_drained();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
